// ===== hdl/flash_nvram_slot_log_assert.svh =====
`ifndef FLASH_NVRAM_SLOT_LOG_ASSERT_SVH
`define FLASH_NVRAM_SLOT_LOG_ASSERT_SVH

`ifndef ASSERT_OFF
`define FLSL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FLSL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FLSL_ASSERT(lbl, prop, msg)
`define FLSL_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hdl/flsl_pkg.sv =====
package flsl_pkg;

  localparam int RECORD_BYTES = 16;
  localparam int MAX_SLOTS    = 256;
  localparam int REC_IDX_W    = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
  localparam int SLOT_W       = 8;
  localparam int CNT_W        = 9;
  localparam int BYTE_W       = 8;

  localparam logic [CNT_W-1:0] SLOT_COUNT_RESET = CNT_W'(MAX_SLOTS);

  typedef enum logic [2:0] {
    KIND_SCAN   = 3'd0,
    KIND_LOAD   = 3'd1,
    KIND_SAVE   = 3'd2,
    KIND_COMMIT = 3'd3,
    KIND_READ   = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ACT_NONE        = 2'd0,
    ACT_WRITE       = 2'd1,
    ACT_ERASE_WRITE = 2'd2,
    ACT_SCAN_DONE   = 2'd3
  } action_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic              slot_empty;
    logic [3:0]        byte_index;
    logic [BYTE_W-1:0] byte_value;
    logic              last_byte;
    logic              op_ok;
  } item_t;

  typedef struct packed {
    action_t           action;
    logic [SLOT_W-1:0] target_slot;
    logic [BYTE_W-1:0] read_data;
    logic              ready_res;
  } result_t;

  function automatic logic [CNT_W-1:0] live_slots(input logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0] res;
    if (cnt == '0) begin
      res = CNT_W'(1);
    end else if (32'(cnt) > MAX_SLOTS) begin
      res = CNT_W'(MAX_SLOTS);
    end else begin
      res = cnt;
    end
    return res;
  endfunction

endpackage

// ===== hdl/flash_nvram_slot_log.sv =====
// channel  | handshake              | beat
// ---------+------------------------+---------------------------------------------
// command  | start & !busy          | kind, slot_empty, byte_index, byte_value,
//          |                        | last_byte, op_ok
// result   | done (one cycle)       | action, target_slot, read_data, ready_res
// config   | cfg_valid & cfg_ready  | cfg_data (slot count)
//
// One command per cycle while busy is low; done and the result are registered
// through the input register, then one decision stage into the result register.
// busy is high from reset until the first edge with rst low; no clearing pass,
// the record stores start unwritten.
// Results cannot be stalled by the receiver.
`include "flash_nvram_slot_log_assert.svh"

module flash_nvram_slot_log
  import flsl_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        kind,
  input  logic              slot_empty,
  input  logic [3:0]        byte_index,
  input  logic [BYTE_W-1:0] byte_value,
  input  logic              last_byte,
  input  logic              op_ok,
  output logic              done,
  output logic [1:0]        action,
  output logic [SLOT_W-1:0] target_slot,
  output logic [BYTE_W-1:0] read_data,
  output logic              ready_res,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CNT_W-1:0]  cfg_data
);

  item_t   item_in, item;
  logic    item_valid;
  result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  assign cfg_ready = !busy;

  assign item_in.kind       = kind;
  assign item_in.slot_empty = slot_empty;
  assign item_in.byte_index = byte_index;
  assign item_in.byte_value = byte_value;
  assign item_in.last_byte  = last_byte;
  assign item_in.op_ok      = op_ok;

  flsl_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (start && !busy),
    .item_in    (item_in),
    .item_valid (item_valid),
    .item       (item)
  );

  flsl_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item       (item),
    .res_valid  (done),
    .res        (res)
  );

  assign action      = res.action;
  assign target_slot = res.target_slot;
  assign read_data   = res.read_data;
  assign ready_res   = res.ready_res;

  `FLSL_ASSERT(a_result_follows, (start && !busy) |-> ##2 done, "command beat without result")
  `FLSL_ASSERT(a_action_after_scan, (done && action != ACT_NONE) |-> ready_res, "action before scan")
  `FLSL_ASSERT(a_erase_slot0, (done && action == ACT_ERASE_WRITE) |-> (target_slot == '0), "erase not to slot 0")
  `FLSL_ASSERT_ALWAYS(a_busy_in_reset, rst |=> busy, "accepting during reset")

endmodule

// ===== hdl/flsl_in_reg.sv =====
module flsl_in_reg
  import flsl_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  load,
  input  item_t item_in,
  output logic  item_valid,
  output item_t item
);

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= item_in;
    end
  end

endmodule

// ===== hdl/flsl_core.sv =====
module flsl_core
  import flsl_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_data,
  input  logic             item_valid,
  input  item_t            item,
  output logic             res_valid,
  output result_t          res
);

  logic [BYTE_W-1:0] cached [RECORD_BYTES];
  logic [BYTE_W-1:0] staged [RECORD_BYTES];
  logic [BYTE_W-1:0] staged_view [RECORD_BYTES];

  logic [CNT_W-1:0]  slot_count;
  logic [SLOT_W-1:0] current_slot, current_slot_next;
  logic [CNT_W-1:0]  scan_position, scan_position_next;
  logic              scan_done, scan_done_next;
  logic              record_changed, record_changed_next;
  logic [SLOT_W-1:0] pending_slot, pending_slot_next;

  logic [CNT_W-1:0]     live;
  logic [REC_IDX_W-1:0] idx;
  logic                 in_rec;
  logic                 save_wr, load_wr, cache_copy;
  logic                 changed, needs_new;
  logic [CNT_W-1:0]     next_slot;
  result_t              res_next;

  assign live      = live_slots(slot_count);
  assign idx       = REC_IDX_W'(item.byte_index);
  assign in_rec    = 32'(item.byte_index) < RECORD_BYTES;
  assign save_wr   = item_valid && (item.kind == KIND_SAVE) && scan_done && in_rec;
  assign load_wr   = item_valid && (item.kind == KIND_LOAD) && in_rec;
  assign next_slot = {1'b0, current_slot} + 1'b1;

  // staged record as it stands once this save beat is written
  always_comb begin
    changed   = 1'b0;
    needs_new = 1'b0;
    for (int i = 0; i < RECORD_BYTES; i++) begin
      staged_view[i] = (save_wr && idx == REC_IDX_W'(i)) ? item.byte_value : staged[i];
      if (cached[i] != staged_view[i]) changed = 1'b1;
      if ((cached[i] & staged_view[i]) != staged_view[i]) needs_new = 1'b1;
    end
  end

  always_comb begin
    current_slot_next   = current_slot;
    scan_position_next  = scan_position;
    scan_done_next      = scan_done;
    record_changed_next = record_changed;
    pending_slot_next   = pending_slot;
    cache_copy          = 1'b0;
    res_next            = '0;
    res_next.action     = ACT_NONE;
    if (item_valid) begin
      case (item.kind)
        KIND_SCAN: begin
          if (!scan_done) begin
            if (item.slot_empty) begin
              current_slot_next = (scan_position == '0) ? '0 :
                                  SLOT_W'(scan_position - 1'b1);
              scan_done_next    = 1'b1;
            end else begin
              current_slot_next  = SLOT_W'(scan_position);
              scan_position_next = scan_position + 1'b1;
              if (scan_position_next >= live) scan_done_next = 1'b1;
            end
            if (scan_done_next) begin
              res_next.action      = ACT_SCAN_DONE;
              res_next.target_slot = current_slot_next;
            end
          end
        end
        KIND_SAVE: begin
          if (scan_done && item.last_byte) begin
            record_changed_next = changed;
            if (changed) begin
              if (!needs_new) begin
                pending_slot_next = current_slot;
                res_next.action   = ACT_WRITE;
              end else if (next_slot >= live) begin
                pending_slot_next = '0;
                res_next.action   = ACT_ERASE_WRITE;
              end else begin
                pending_slot_next = SLOT_W'(next_slot);
                res_next.action   = ACT_WRITE;
              end
              res_next.target_slot = pending_slot_next;
            end
          end
        end
        KIND_COMMIT: begin
          if (record_changed) begin
            if (item.op_ok) begin
              current_slot_next = pending_slot;
              cache_copy        = 1'b1;
            end
            record_changed_next = 1'b0;
          end
        end
        KIND_READ: begin
          if (in_rec) res_next.read_data = cached[idx];
        end
        default: begin
        end
      endcase
    end
    res_next.ready_res = scan_done_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count     <= SLOT_COUNT_RESET;
      current_slot   <= '0;
      scan_position  <= '0;
      scan_done      <= 1'b0;
      record_changed <= 1'b0;
      pending_slot   <= '0;
      res_valid      <= 1'b0;
    end else begin
      if (cfg_we) slot_count <= cfg_data;
      current_slot   <= current_slot_next;
      scan_position  <= scan_position_next;
      scan_done      <= scan_done_next;
      record_changed <= record_changed_next;
      pending_slot   <= pending_slot_next;
      res_valid      <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
    if (save_wr) staged[idx] <= item.byte_value;
    if (cache_copy) begin
      for (int i = 0; i < RECORD_BYTES; i++) cached[i] <= staged[i];
    end else if (load_wr) begin
      cached[idx] <= item.byte_value;
    end
  end

endmodule
